>>> rtl/articulation_point_finder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the articulation point finder
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ARTICULATION_POINT_FINDER_DEFINES_SVH
`define ARTICULATION_POINT_FINDER_DEFINES_SVH

// same-cycle implication
`define APF_ASSERT_NOW(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define APF_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package apf_pkg;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ADD,
        DP_CLEAR,
        DP_RUN_INIT,
        DP_ROOT_SKIP,
        DP_ROOT_START,
        DP_SCAN_SKIP,
        DP_PUSH,
        DP_PUSH_WR,
        DP_BACK_REQ,
        DP_BACK_UPD,
        DP_WALK_END,
        DP_POP,
        DP_POP1,
        DP_POP2,
        DP_EMIT_INIT,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic scan_end;
        logic edge_hit;
        logic edge_unvisited;
        logic at_root;
        logic n_zero;
        logic emit_last;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/apf_ram.sv
// ----------------------------------------------------------------------------
// apf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/apf_ctrl.sv
// ----------------------------------------------------------------------------
// apf_ctrl
// Sequencer for edge load, depth-first walk and result emission.
// ----------------------------------------------------------------------------
module apf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    output logic                in_ready,
    input  apf_pkg::dp_status_t status,
    output apf_pkg::dp_op_t     op
);
    import apf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_SCAN,
        S_PUSHW,
        S_BACK,
        S_POP1,
        S_POP2,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(in_cmd))
                        CMD_ADD:   op = DP_ADD;
                        CMD_CLEAR: op = DP_CLEAR;
                        CMD_RUN:
                        begin
                            op         = DP_RUN_INIT;
                            state_next = S_ROOT;
                        end
                        default:   op = DP_NOP;
                    endcase
                end
            end
            S_ROOT:
            begin
                if (status.root_done)
                begin
                    op         = DP_EMIT_INIT;
                    state_next = status.n_zero ? S_IDLE : S_EMIT;
                end
                else if (status.root_visited)
                begin
                    op = DP_ROOT_SKIP;
                end
                else
                begin
                    op         = DP_ROOT_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    if (status.at_root)
                    begin
                        op         = DP_WALK_END;
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        op         = DP_POP;
                        state_next = S_POP1;
                    end
                end
                else if (status.edge_hit && status.edge_unvisited)
                begin
                    op         = DP_PUSH;
                    state_next = S_PUSHW;
                end
                else if (status.edge_hit)
                begin
                    op         = DP_BACK_REQ;
                    state_next = S_BACK;
                end
                else
                begin
                    op = DP_SCAN_SKIP;
                end
            end
            S_PUSHW:
            begin
                op         = DP_PUSH_WR;
                state_next = S_SCAN;
            end
            S_BACK:
            begin
                op         = DP_BACK_UPD;
                state_next = S_SCAN;
            end
            S_POP1:
            begin
                op         = DP_POP1;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                op         = DP_POP2;
                state_next = S_SCAN;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    op = DP_EMIT;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/apf_dp.sv
// ----------------------------------------------------------------------------
// apf_dp
// Adjacency matrix, walk registers, stack and time RAMs, result register.
// ----------------------------------------------------------------------------
`include "articulation_point_finder_defines.svh"

module apf_dp #(
    parameter int MAX_NODES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  apf_pkg::dp_op_t     op,
    output apf_pkg::dp_status_t status,
    input  logic [4:0]          edge_from,
    input  logic [4:0]          edge_to,
    input  logic                cfg_we,
    input  logic [5:0]          cfg_wdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          out_node,
    output logic                out_cut,
    output logic                out_last
);
    import apf_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = NW + CW;
    localparam int DW = 2 * CW;

    logic [MAX_NODES-1:0] adj_reg [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg;
    logic [MAX_NODES-1:0] cut_reg;
    logic [5:0]           node_count_reg;
    logic [CW-1:0]        timer_reg;
    logic [CW-1:0]        rc_reg;
    logic [CW-1:0]        i_reg;
    logic [NW-1:0]        u_reg;
    logic [CW-1:0]        v_reg;
    logic [CW-1:0]        low_reg;
    logic [CW-1:0]        disc_reg;
    logic [CW-1:0]        child_low_reg;
    logic [NW-1:0]        parent_reg;
    logic                 have_parent_reg;
    logic [NW-1:0]        top_reg;
    logic                 out_valid_reg;
    logic [4:0]           out_node_reg;
    logic                 out_cut_reg;
    logic                 out_last_reg;

    logic [CW-1:0] n_eff;
    logic [NW-1:0] w;
    logic [NW-1:0] ia;
    logic [NW-1:0] ib;
    logic          add_ok;

    logic          dl_we;
    logic [NW-1:0] dl_waddr;
    logic [DW-1:0] dl_wdata;
    logic [NW-1:0] dl_raddr;
    logic [DW-1:0] dl_rdata;
    logic [CW-1:0] rd_disc;
    logic [CW-1:0] rd_low;

    logic          stk_we;
    logic [SW-1:0] stk_wdata;
    logic [NW-1:0] stk_raddr;
    logic [SW-1:0] stk_rdata;
    logic [NW-1:0] rd_node;
    logic [CW-1:0] rd_cur;

    always_comb
    begin
        if ({2'b00, node_count_reg} > 8'(MAX_NODES))
        begin
            n_eff = CW'(MAX_NODES);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    assign w      = v_reg[NW-1:0];
    assign ia     = NW'(edge_from);
    assign ib     = NW'(edge_to);
    assign add_ok = (edge_from != edge_to) && (8'(edge_from) < 8'(n_eff))
                    && (8'(edge_to) < 8'(n_eff));

    assign rd_disc = dl_rdata[DW-1:CW];
    assign rd_low  = dl_rdata[CW-1:0];
    assign rd_node = stk_rdata[SW-1:CW];
    assign rd_cur  = stk_rdata[CW-1:0];

    // status toward the sequencer
    always_comb
    begin
        status.root_done      = (i_reg >= n_eff);
        status.root_visited   = visited_reg[i_reg[NW-1:0]];
        status.scan_end       = (v_reg >= n_eff);
        status.edge_hit       = adj_reg[u_reg][w] && !(have_parent_reg && (w == parent_reg));
        status.edge_unvisited = !visited_reg[w];
        status.at_root        = (top_reg == '0);
        status.n_zero         = (n_eff == '0);
        status.emit_last      = ((i_reg + CW'(1)) == n_eff);
        status.out_busy       = out_valid_reg && !out_ready;
    end

    // time and stack RAM port muxing
    always_comb
    begin
        dl_we    = (op == DP_ROOT_START) || (op == DP_PUSH) || (op == DP_PUSH_WR);
        dl_waddr = (op == DP_ROOT_START) ? i_reg[NW-1:0] : u_reg;
        dl_wdata = (op == DP_ROOT_START) ? {timer_reg, timer_reg} : {disc_reg, low_reg};
        dl_raddr = (op == DP_POP1) ? rd_node : w;
        stk_we    = (op == DP_PUSH);
        stk_wdata = {u_reg, v_reg + CW'(1)};
        stk_raddr = top_reg - NW'(1);
    end

    apf_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dl_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    apf_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (top_reg),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // adjacency matrix and node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_NODES; r++)
            begin
                adj_reg[r] <= '0;
            end
            node_count_reg <= 6'd32;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (op == DP_CLEAR)
            begin
                for (int r = 0; r < MAX_NODES; r++)
                begin
                    adj_reg[r] <= '0;
                end
            end
            else if ((op == DP_ADD) && add_ok)
            begin
                adj_reg[ia][ib] <= 1'b1;
                adj_reg[ib][ia] <= 1'b1;
            end
        end
    end

    // walk control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg     <= '0;
            cut_reg         <= '0;
            timer_reg       <= '0;
            rc_reg          <= '0;
            i_reg           <= '0;
            top_reg         <= '0;
            have_parent_reg <= 1'b0;
            v_reg           <= '0;
            u_reg           <= '0;
            disc_reg        <= '0;
            low_reg         <= '0;
            child_low_reg   <= '0;
            parent_reg      <= '0;
            out_valid_reg   <= 1'b0;
            out_node_reg    <= '0;
            out_cut_reg     <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            // a new beat loaded by emit replaces the one taken this cycle
            if (out_valid_reg && out_ready && (op != DP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                DP_RUN_INIT:
                begin
                    visited_reg <= '0;
                    cut_reg     <= '0;
                    timer_reg   <= '0;
                    i_reg       <= '0;
                end
                DP_ROOT_SKIP:
                begin
                    i_reg <= i_reg + CW'(1);
                end
                DP_ROOT_START:
                begin
                    visited_reg[i_reg[NW-1:0]] <= 1'b1;
                    u_reg           <= i_reg[NW-1:0];
                    v_reg           <= '0;
                    disc_reg        <= timer_reg;
                    low_reg         <= timer_reg;
                    timer_reg       <= timer_reg + CW'(1);
                    top_reg         <= '0;
                    have_parent_reg <= 1'b0;
                    rc_reg          <= '0;
                end
                DP_SCAN_SKIP:
                begin
                    v_reg <= v_reg + CW'(1);
                end
                DP_PUSH:
                begin
                    if (top_reg == '0)
                    begin
                        rc_reg <= rc_reg + CW'(1);
                    end
                    visited_reg[w]  <= 1'b1;
                    parent_reg      <= u_reg;
                    have_parent_reg <= 1'b1;
                    top_reg         <= top_reg + NW'(1);
                    u_reg           <= w;
                    v_reg           <= '0;
                    disc_reg        <= timer_reg;
                    low_reg         <= timer_reg;
                    timer_reg       <= timer_reg + CW'(1);
                end
                DP_BACK_REQ:
                begin
                    v_reg <= v_reg + CW'(1);
                end
                DP_BACK_UPD:
                begin
                    if (rd_disc < low_reg)
                    begin
                        low_reg <= rd_disc;
                    end
                end
                DP_WALK_END:
                begin
                    if (rc_reg > CW'(1))
                    begin
                        cut_reg[u_reg] <= 1'b1;
                    end
                    i_reg <= i_reg + CW'(1);
                end
                DP_POP:
                begin
                    child_low_reg <= low_reg;
                    top_reg       <= top_reg - NW'(1);
                end
                DP_POP1:
                begin
                    u_reg <= rd_node;
                    v_reg <= rd_cur;
                end
                DP_POP2:
                begin
                    disc_reg <= rd_disc;
                    low_reg  <= (child_low_reg < rd_low) ? child_low_reg : rd_low;
                    if (top_reg != '0)
                    begin
                        parent_reg      <= rd_node;
                        have_parent_reg <= 1'b1;
                        if (child_low_reg >= rd_disc)
                        begin
                            cut_reg[u_reg] <= 1'b1;
                        end
                    end
                    else
                    begin
                        have_parent_reg <= 1'b0;
                    end
                end
                DP_EMIT_INIT:
                begin
                    i_reg <= '0;
                end
                DP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_node_reg  <= 5'(i_reg);
                    out_cut_reg   <= cut_reg[i_reg[NW-1:0]];
                    out_last_reg  <= ((i_reg + CW'(1)) == n_eff);
                    i_reg         <= i_reg + CW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_cut   = out_cut_reg;
    assign out_last  = out_last_reg;

    `APF_ASSERT_NEXT(a_run_clears, op == DP_RUN_INIT, visited_reg == '0 && cut_reg == '0, "run init left flags set")
    `APF_ASSERT_NOW(a_no_overflow, op == DP_PUSH, top_reg != NW'(MAX_NODES - 1), "walk stack overflow")
    `APF_ASSERT_NOW(a_timer_range, op == DP_PUSH || op == DP_ROOT_START, timer_reg < n_eff, "timer past node count")
    `APF_ASSERT_NEXT(a_emit_only, op != DP_EMIT && !out_valid_reg, !out_valid_reg, "result without emit")

endmodule

>>> rtl/articulation_point_finder.sv
// Walk: each scan step tests one neighbor; a back-edge probe adds a BACK step, a tree
// edge a PUSHW step going down and POP, POP1 and POP2 steps coming back up.
// Then n result beats, one per cycle while m_axis_tready stays high.
// Add, clear and reserved commands complete without leaving idle; one command at a time.
// Throughput is set by the single-bit neighbor scan of the sequencer.
// Reset (rst_n, async low) clears the adjacency matrix, control and node_count=32.
// ----------------------------------------------------------------------------
// articulation_point_finder
// Cut-vertex finder: loads undirected edges, runs an iterative Tarjan walk
// and streams one result beat per node.
// ----------------------------------------------------------------------------
module articulation_point_finder #(
    parameter int MAX_NODES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [4:0] edge_from, [9:5] edge_to, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] node_index, [5] is_cut_vertex, rest zero
    output logic        m_axis_tlast,   // last_node
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata       // node_count
);
    import apf_pkg::*;

    dp_op_t     op;
    dp_status_t status;
    logic [4:0] out_node;
    logic       out_cut;

    // sequencer: one state per walk step, commands datapath by op code
    apf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .op       (op)
    );

    // datapath: adjacency flops, stack and time RAMs, output register
    apf_dp #(.MAX_NODES(MAX_NODES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .edge_from (s_axis_tdata[4:0]),
        .edge_to   (s_axis_tdata[9:5]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_node  (out_node),
        .out_cut   (out_cut),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_cut, out_node};

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// articulation_point_finder testbench
// Drives add/run/clear/reserved command beats under several node_count settings and
// checks every result beat against a cut-vertex search kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import apf_pkg::*;

    localparam int NODES_MAX   = 32;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 12;

    typedef struct {
        cmd_t       cmd;
        logic [4:0] a;
        logic [4:0] b;
    } cmd_beat_t;

    typedef struct {
        logic [4:0] node;
        logic       cut;
        logic       last;
    } node_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [4:0] edge_from, [9:5] edge_to
    logic [1:0]  s_axis_tuser = '0;   // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [4:0] node_index, [5] is_cut_vertex
    logic        m_axis_tlast;        // last_node
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    cmd_beat_t    cmd_queue[$];
    node_report_t report_queue[$];

    logic [31:0] graph_rows [NODES_MAX];
    logic [5:0]  model_count = 6'd32;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycles = 0;
    int          errors = 0;
    int          searches = 0;
    int          reports = 0;
    bit          took_beat = 1'b0;
    cmd_beat_t   next_beat;

    articulation_point_finder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    function automatic int live_nodes();
        return (model_count > NODES_MAX) ? NODES_MAX : int'(model_count);
    endfunction

    // Iterative Tarjan walk over graph_rows; returns one cut bit per node.
    function automatic logic [31:0] find_cut_nodes(int n);
        logic [31:0] seen;
        logic [31:0] cuts;
        int disc [NODES_MAX];
        int low [NODES_MAX];
        int stk_node [NODES_MAX];
        int stk_cur [NODES_MAX];
        int timer, sp, depth, u, v, par, w, p, kids;
        bit has_par, pushed;
        seen = '0;
        cuts = '0;
        timer = 0;
        for (int r = 0; r < n; r++)
        begin
            if (seen[r])
                continue;
            kids = 0;
            seen[r] = 1'b1;
            disc[r] = timer;
            low[r] = timer;
            timer++;
            stk_node[0] = r;
            stk_cur[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                depth = sp - 1;
                u = stk_node[depth];
                v = stk_cur[depth];
                has_par = depth > 0;
                par = has_par ? stk_node[depth - 1] : 0;
                pushed = 1'b0;
                while (v < n && !pushed)
                begin
                    w = v;
                    v++;
                    if (!graph_rows[u][w] || (has_par && w == par))
                        continue;
                    if (!seen[w])
                    begin
                        stk_cur[depth] = v;
                        seen[w] = 1'b1;
                        disc[w] = timer;
                        low[w] = timer;
                        timer++;
                        if (sp < NODES_MAX)
                        begin
                            stk_node[sp] = w;
                            stk_cur[sp] = 0;
                            sp++;
                        end
                        if (depth == 0)
                            kids++;
                        pushed = 1'b1;
                    end
                    else if (disc[w] < low[u])
                        low[u] = disc[w];
                end
                if (pushed)
                    continue;
                stk_cur[depth] = v;
                sp--;
                if (sp > 0)
                begin
                    p = stk_node[sp - 1];
                    if (low[u] < low[p])
                        low[p] = low[u];
                    // non-root parent: child cannot climb above it
                    if (sp > 1 && low[u] >= disc[p])
                        cuts[p] = 1'b1;
                end
            end
            // root splits the tree only with two or more tree children
            if (kids > 1)
                cuts[r] = 1'b1;
        end
        return cuts;
    endfunction

    // Apply one accepted command beat to the graph copy; queue run reports.
    task automatic apply_command(cmd_t cmd, logic [4:0] a, logic [4:0] b);
        int n;
        logic [31:0] cuts;
        node_report_t rep;
        n = live_nodes();
        case (cmd)
            CMD_ADD:
            begin
                // self-loops and out-of-range endpoints are dropped
                if (a != b && a < n && b < n)
                begin
                    graph_rows[a][b] = 1'b1;
                    graph_rows[b][a] = 1'b1;
                end
            end
            CMD_CLEAR:
                for (int i = 0; i < NODES_MAX; i++)
                    graph_rows[i] = '0;
            CMD_RUN:
            begin
                searches++;
                cuts = find_cut_nodes(n);
                for (int i = 0; i < n; i++)
                begin
                    rep.node = i[4:0];
                    rep.cut = cuts[i];
                    rep.last = (i == n - 1);
                    report_queue.insert(report_queue.size(), rep);
                end
            end
            default:;
        endcase
    endtask

    // Input side monitor: an accepted beat updates the prediction.
    always @(posedge clk)
    begin
        took_beat <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            apply_command(cmd_t'(s_axis_tuser), s_axis_tdata[4:0], s_axis_tdata[9:5]);
    end

    // Driver: inputs move on the falling edge only.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (!s_axis_tvalid || took_beat)
            begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= next_beat.cmd;
                    s_axis_tdata <= {6'b0, next_beat.b, next_beat.a};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each result beat with the oldest report.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("articulation_point_finder test failed");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            reports++;
            if (report_queue.size() == 0)
            begin
                $error("unexpected result beat, node_index %0d", m_axis_tdata[4:0]);
                errors++;
            end
            else
            begin
                automatic node_report_t want = report_queue.pop_front();
                if (m_axis_tdata[4:0] !== want.node)
                begin
                    $error("node_index: expected %0d, got %0d", want.node, m_axis_tdata[4:0]);
                    errors++;
                end
                if (m_axis_tdata[5] !== want.cut)
                begin
                    $error("is_cut_vertex: expected %0d, got %0d", want.cut, m_axis_tdata[5]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_node: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tdata[7:6] !== 2'b00)
                begin
                    $error("tdata pad: expected 0, got %0d", m_axis_tdata[7:6]);
                    errors++;
                end
            end
        end
    end

    task automatic send(cmd_t cmd, int a, int b);
        cmd_beat_t beat;
        beat.cmd = cmd;
        beat.a = a[4:0];
        beat.b = b[4:0];
        cmd_queue.insert(cmd_queue.size(), beat);
    endtask

    // Sender holds off until everything is drained, then lets the block settle.
    task automatic drain();
        wait (cmd_queue.size() == 0 && !s_axis_tvalid && report_queue.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_node_count(int value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[5:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        model_count = value[5:0];
    endtask

    function automatic int pick_node(int n);
        if (n == 0 || $urandom_range(4) == 0)
            return $urandom_range(31);
        return $urandom_range(n - 1);
    endfunction

    task automatic random_batch(int count);
        int n, roll;
        n = live_nodes();
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 74)
                send(CMD_ADD, pick_node(n), pick_node(n));
            else if (roll < 90)
                send(CMD_RUN, $urandom_range(31), $urandom_range(31));
            else if (roll < 96)
                send(CMD_CLEAR, $urandom_range(31), $urandom_range(31));
            else
                send(CMD_NONE, $urandom_range(31), $urandom_range(31));
        end
        send(CMD_RUN, 0, 0);
    endtask

    int phase_counts[] = '{63, 1, 2, 5, 9, 17, 32, 0, 3, 32, 24};

    initial
    begin
        for (int i = 0; i < NODES_MAX; i++)
            graph_rows[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset count, extremes, self-loop, reserved command
        send_idle_pct = 27;
        recv_idle_pct = 64;
        send(CMD_RUN, 0, 0);
        send(CMD_ADD, 0, 31);
        send(CMD_ADD, 31, 31);
        send(CMD_ADD, 0, 1);
        send(CMD_ADD, 1, 2);
        send(CMD_NONE, 2, 3);
        send(CMD_ADD, 2, 0);
        send(CMD_ADD, 2, 3);
        send(CMD_RUN, 31, 31);
        send(CMD_CLEAR, 31, 0);
        send(CMD_ADD, 4, 5);
        send(CMD_ADD, 5, 6);
        send(CMD_ADD, 4, 6);
        send(CMD_RUN, 0, 0);
        // stale edges above a lowered count, then out-of-range adds
        set_node_count(5);
        send(CMD_RUN, 0, 0);
        send(CMD_ADD, 3, 7);
        send(CMD_ADD, 0, 4);
        send(CMD_ADD, 4, 2);
        send(CMD_RUN, 0, 0);
        set_node_count(0);
        send(CMD_ADD, 0, 1);
        send(CMD_RUN, 0, 0);
        set_node_count(1);
        send(CMD_RUN, 0, 0);

        foreach (phase_counts[k])
        begin
            set_node_count(phase_counts[k]);
            if (k < 4)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 64;
            end
            else if (k < 8)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_batch(22);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Covered %0d searches over %0d node_count settings, %0d result beats.",
                 searches, phase_counts.size() + 3, reports);
        if (errors == 0 && report_queue.size() == 0)
            $display("articulation_point_finder test passed");
        else
            $display("articulation_point_finder test failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/apf_pkg.sv
rtl/apf_ram.sv
rtl/apf_ctrl.sv
rtl/apf_dp.sv
rtl/articulation_point_finder.sv
sim/testbench.sv
